/* sv/sm83_pkg.sv */
package sm83_pkg;

   typedef enum logic [4:0] {
      ACT_ADC  = 5'd0,
      ACT_ADD  = 5'd1,
      ACT_SUB  = 5'd2,
      ACT_SBC  = 5'd3,
      ACT_AND  = 5'd4,
      ACT_OR   = 5'd5,
      ACT_XOR  = 5'd6,
      ACT_BIT  = 5'd7,
      ACT_CP   = 5'd8,
      ACT_RL   = 5'd9,
      ACT_RLC  = 5'd10,
      ACT_RR   = 5'd11,
      ACT_RRC  = 5'd12,
      ACT_SLA  = 5'd13,
      ACT_SRA  = 5'd14,
      ACT_SRL  = 5'd15,
      ACT_SWAP = 5'd16,
      ACT_SCF  = 5'd17,
      ACT_CCF  = 5'd18,
      ACT_CPL  = 5'd19,
      ACT_DAA  = 5'd20,
      ACT_INC  = 5'd21,
      ACT_DEC  = 5'd22,
      ACT_LOAD = 5'd23
   } action_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [7:0] result;
      logic [7:0] acc;
      flags_type  flags;
   } alu_out_type;

   localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

endpackage

/* sv/sm83_alu.sv */
module sm83_alu (
   input  logic [4:0]            action,
   input  logic [7:0]            value,
   input  logic [7:0]            first_operand,
   input  logic [2:0]            bit_index,
   input  logic [7:0]            acc,
   input  sm83_pkg::flags_type   flags,
   output sm83_pkg::alu_out_type alu_out
);
   import sm83_pkg::*;

   logic       cin;
   logic       sub_cin;
   logic [8:0] adc_sum;
   logic [4:0] adc_half;
   logic [8:0] add_sum;
   logic [4:0] add_half;
   logic [8:0] sub_diff;
   logic [4:0] sub_half;
   logic       daa_lo;
   logic       daa_hi;
   logic [7:0] daa_adj;
   logic [7:0] daa_acc;
   logic [7:0] inc_val;
   logic [7:0] dec_val;

   assign cin      = flags.c;
   assign sub_cin  = (action == ACT_SBC) ? cin : 1'b0;
   assign adc_sum  = {1'b0, acc} + {1'b0, value} + {8'd0, cin};
   assign adc_half = {1'b0, acc[3:0]} + {1'b0, value[3:0]} + {4'd0, cin};
   assign add_sum  = {1'b0, first_operand} + {1'b0, value};
   assign add_half = {1'b0, first_operand[3:0]} + {1'b0, value[3:0]};
   // bit 8 / bit 4 of the difference is the borrow out
   assign sub_diff = {1'b0, acc} - {1'b0, value} - {8'd0, sub_cin};
   assign sub_half = {1'b0, acc[3:0]} - {1'b0, value[3:0]} - {4'd0, sub_cin};

   assign daa_lo  = flags.h | (~flags.n & (acc[3:0] > DAA_LO_LIMIT));
   assign daa_hi  = cin | (~flags.n & (acc > DAA_HI_LIMIT));
   assign daa_adj = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
   assign daa_acc = flags.n ? (acc - daa_adj) : (acc + daa_adj);

   assign inc_val = value + 8'd1;
   assign dec_val = value - 8'd1;

   always_comb begin
      logic [7:0] r;
      logic       ret_r;
      logic [7:0] acc_n;
      flags_type  fl_n;

      r     = 8'd0;
      ret_r = 1'b0;
      acc_n = acc;
      fl_n  = flags;

      case (action_type'(action))
         ACT_ADC: begin
            acc_n = adc_sum[7:0];
            fl_n  = '{z: (adc_sum[7:0] == 8'd0), n: 1'b0, h: adc_half[4], c: adc_sum[8]};
         end
         ACT_ADD: begin
            acc_n = add_sum[7:0];
            fl_n  = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
         end
         ACT_SUB, ACT_SBC: begin
            acc_n = sub_diff[7:0];
            fl_n  = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
         end
         ACT_CP: begin
            fl_n = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
         end
         ACT_AND: begin
            acc_n = acc & value;
            fl_n  = '{z: ((acc & value) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         ACT_OR: begin
            acc_n = acc | value;
            fl_n  = '{z: ((acc | value) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_XOR: begin
            acc_n = acc ^ value;
            fl_n  = '{z: ((acc ^ value) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_BIT: begin
            fl_n.z = ~value[bit_index];
            fl_n.n = 1'b0;
            fl_n.h = 1'b1;
         end
         ACT_RL: begin
            r     = {value[6:0], cin};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[7]};
         end
         ACT_RLC: begin
            r     = {value[6:0], value[7]};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[7]};
         end
         ACT_RR: begin
            r     = {cin, value[7:1]};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[0]};
         end
         ACT_RRC: begin
            r     = {value[0], value[7:1]};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[0]};
         end
         ACT_SLA: begin
            r     = {value[6:0], 1'b0};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[7]};
         end
         ACT_SRA: begin
            r     = {value[7], value[7:1]};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[0]};
         end
         ACT_SRL: begin
            r     = {1'b0, value[7:1]};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: value[0]};
         end
         ACT_SWAP: begin
            r     = {value[3:0], value[7:4]};
            ret_r = 1'b1;
            fl_n  = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_SCF: begin
            fl_n.n = 1'b0;
            fl_n.h = 1'b0;
            fl_n.c = 1'b1;
         end
         ACT_CCF: begin
            fl_n.n = 1'b0;
            fl_n.h = 1'b0;
            fl_n.c = ~cin;
         end
         ACT_CPL: begin
            acc_n  = ~acc;
            fl_n.n = 1'b1;
            fl_n.h = 1'b1;
         end
         ACT_DAA: begin
            // N is left as it was
            acc_n  = daa_acc;
            fl_n.z = (daa_acc == 8'd0);
            fl_n.h = 1'b0;
            fl_n.c = daa_hi;
         end
         ACT_INC: begin
            r      = inc_val;
            ret_r  = 1'b1;
            fl_n.z = (inc_val == 8'd0);
            fl_n.n = 1'b0;
            fl_n.h = (inc_val[3:0] == 4'h0);
         end
         ACT_DEC: begin
            r      = dec_val;
            ret_r  = 1'b1;
            fl_n.z = (dec_val == 8'd0);
            fl_n.n = 1'b1;
            fl_n.h = (dec_val[3:0] == 4'hF);
         end
         ACT_LOAD: begin
            acc_n = value;
            fl_n  = flags_type'(first_operand[7:4]);
         end
         default: begin
            // undefined codes leave everything as it is
            acc_n = acc;
         end
      endcase

      alu_out.result = ret_r ? r : acc_n;
      alu_out.acc    = acc_n;
      alu_out.flags  = fl_n;
   end

endmodule

/* sv/sm83_alu_with_flags.sv */
// SM83 ALU with accumulator and Z/N/H/C flags.
// Input channel req_*: one word per operation (action, value, first_operand,
// bit_index), taken when req_valid and req_ready are both high.
// Result channel rsp_*: one word per operation carrying the produced byte,
// the accumulator and the four flags after that operation.
// A taken word passes through the input register and then the result
// register before it is offered on rsp_*. Throughput is one word per
// cycle while the receiver does not stall: the input register feeds the ALU,
// and the accumulator, flags and result register all load together in the
// same cycle, so the next word sees the updated state without a gap.
// When the receiver stalls the result register holds, the input register
// fills, and req_ready drops until rsp_ready returns.
// Reset (synchronous, active high) clears the accumulator, the flags and
// both valid bits; no word is pending afterwards.
module sm83_alu_with_flags (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_action,
   input  logic [7:0] req_value,
   input  logic [7:0] req_first_operand,
   input  logic [2:0] req_bit_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result,
   output logic [7:0] rsp_accumulator_out,
   output logic       rsp_flag_zero,
   output logic       rsp_flag_subtract,
   output logic       rsp_flag_half,
   output logic       rsp_flag_carry
);
   import sm83_pkg::*;

   logic        in_valid_ff;
   logic [4:0]  action_ff;
   logic [7:0]  value_ff;
   logic [7:0]  first_operand_ff;
   logic [2:0]  bit_index_ff;
   logic [7:0]  acc_ff;
   flags_type   flags_ff;
   logic        out_valid_ff;
   alu_out_type out_ff;
   alu_out_type alu_res;
   logic        advance;
   logic        in_valid_in;
   logic        out_valid_in;

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   assign in_valid_in  = (req_valid & req_ready) | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   sm83_alu u_alu (
      .action        (action_ff),
      .value         (value_ff),
      .first_operand (first_operand_ff),
      .bit_index     (bit_index_ff),
      .acc           (acc_ff),
      .flags         (flags_ff),
      .alu_out       (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            acc_ff   <= alu_res.acc;
            flags_ff <= alu_res.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         action_ff        <= req_action;
         value_ff         <= req_value;
         first_operand_ff <= req_first_operand;
         bit_index_ff     <= req_bit_index;
      end
      if (advance) begin
         out_ff <= alu_res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result          = out_ff.result;
   assign rsp_accumulator_out = out_ff.acc;
   assign rsp_flag_zero       = out_ff.flags.z;
   assign rsp_flag_subtract   = out_ff.flags.n;
   assign rsp_flag_half       = out_ff.flags.h;
   assign rsp_flag_carry      = out_ff.flags.c;

   // a pending result word always mirrors the architectural state
   a_out_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.acc == acc_ff) && (out_ff.flags == flags_ff))
      else $error("result word differs from accumulator/flags");

   // a stalled output must keep a loaded input word in place
   a_in_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> in_valid_ff && $stable(acc_ff))
      else $error("input word lost or state moved during stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !in_valid_ff && (acc_ff == 8'd0) && (flags_ff == '0))
      else $error("reset did not clear state");

endmodule

/* verif/tb_sm83_alu_with_flags.sv */
`timescale 1ns / 1ps

module tb_sm83_alu_with_flags;
   import sm83_pkg::*;

   localparam logic [4:0] ACT_UNUSED   = 5'd31;
   localparam logic [7:0] DAA_FIX_HI   = 8'h60;
   localparam logic [7:0] DAA_FIX_LO   = 8'h06;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         CYCLE_LIMIT  = 400000;

   // Tracks accumulator and flags and queues the words the block should return.
   class acc_flag_board;
      logic [7:0]  acc;
      flags_type   flg;
      alu_out_type pending_outs[$];
      int unsigned errors;

      function new();
         acc    = '0;
         flg    = '0;
         errors = 0;
      endfunction

      function void note_word(logic [4:0] act, logic [7:0] v, logic [7:0] v1,
                              logic [2:0] bi);
         logic [7:0]  a;
         logic        cin;
         logic [8:0]  full;
         logic [7:0]  r;
         logic        ret_byte;
         logic [7:0]  adj;
         alu_out_type want;
         a        = acc;
         cin      = flg.c;
         r        = '0;
         ret_byte = 1'b0;
         case (act)
            ACT_ADC: begin
               full  = {1'b0, a} + {1'b0, v} + {8'd0, cin};
               acc   = full[7:0];
               flg.z = (acc == 8'h00);
               flg.n = 1'b0;
               // half carry from the accumulator as it was before the write
               flg.h = ({1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin}) > 5'h0F;
               flg.c = full[8];
            end
            ACT_ADD: begin
               full  = {1'b0, v1} + {1'b0, v};
               acc   = full[7:0];
               flg.z = (acc == 8'h00);
               flg.n = 1'b0;
               flg.h = ({1'b0, v1[3:0]} + {1'b0, v[3:0]}) > 5'h0F;
               flg.c = full[8];
            end
            ACT_SUB, ACT_CP: begin
               if (act == ACT_SUB)
                  acc = a - v;
               flg.z = (a == v);
               flg.n = 1'b1;
               flg.h = a[3:0] < v[3:0];
               flg.c = a < v;
            end
            ACT_SBC: begin
               acc   = a - v - {7'd0, cin};
               flg.z = (acc == 8'h00);
               flg.n = 1'b1;
               flg.h = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + {4'd0, cin});
               flg.c = {1'b0, a} < ({1'b0, v} + {8'd0, cin});
            end
            ACT_AND, ACT_OR, ACT_XOR: begin
               if (act == ACT_AND)
                  acc = a & v;
               else if (act == ACT_OR)
                  acc = a | v;
               else
                  acc = a ^ v;
               flg.z = (acc == 8'h00);
               flg.n = 1'b0;
               flg.h = (act == ACT_AND);
               flg.c = 1'b0;
            end
            ACT_BIT: begin
               flg.z = ~v[bi];
               flg.n = 1'b0;
               flg.h = 1'b1;
            end
            ACT_RL, ACT_RLC, ACT_RR, ACT_RRC, ACT_SLA, ACT_SRA, ACT_SRL,
            ACT_SWAP: begin
               case (act)
                  ACT_RL:  r = {v[6:0], cin};
                  ACT_RLC: r = {v[6:0], v[7]};
                  ACT_RR:  r = {cin, v[7:1]};
                  ACT_RRC: r = {v[0], v[7:1]};
                  ACT_SLA: r = {v[6:0], 1'b0};
                  ACT_SRA: r = {v[7], v[7:1]};
                  ACT_SRL: r = {1'b0, v[7:1]};
                  default: r = {v[3:0], v[7:4]};
               endcase
               flg.z = (r == 8'h00);
               flg.n = 1'b0;
               flg.h = 1'b0;
               if (act == ACT_SWAP)
                  flg.c = 1'b0;
               else if (act == ACT_RL || act == ACT_RLC || act == ACT_SLA)
                  flg.c = v[7];
               else
                  flg.c = v[0];
               ret_byte = 1'b1;
            end
            ACT_SCF, ACT_CCF: begin
               flg.n = 1'b0;
               flg.h = 1'b0;
               flg.c = (act == ACT_SCF) ? 1'b1 : ~cin;
            end
            ACT_CPL: begin
               acc   = ~a;
               flg.n = 1'b1;
               flg.h = 1'b1;
            end
            ACT_DAA: begin
               adj = cin ? DAA_FIX_HI : 8'h00;
               if (flg.h || (!flg.n && a[3:0] > DAA_LO_LIMIT))
                  adj = adj | DAA_FIX_LO;
               if (cin || (!flg.n && a > DAA_HI_LIMIT))
                  adj = adj | DAA_FIX_HI;
               acc   = flg.n ? a - adj : a + adj;
               flg.c = adj >= DAA_FIX_HI;
               flg.h = 1'b0;
               flg.z = (acc == 8'h00);
            end
            ACT_INC, ACT_DEC: begin
               r        = (act == ACT_INC) ? v + 8'h01 : v - 8'h01;
               flg.z    = (r == 8'h00);
               flg.n    = (act == ACT_DEC);
               flg.h    = (act == ACT_INC) ? (r[3:0] == 4'h0) : (r[3:0] == 4'hF);
               ret_byte = 1'b1;
            end
            ACT_LOAD: begin
               acc = v;
               flg = flags_type'(v1[7:4]);
            end
            default: ;
         endcase
         want.result = ret_byte ? r : acc;
         want.acc    = acc;
         want.flags  = flg;
         pending_outs.push_back(want);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(alu_out_type got);
         alu_out_type want;
         if (pending_outs.size() == 0) begin
            $error("result word with nothing outstanding");
            errors++;
         end else begin
            want = pending_outs.pop_front();
            check_field("result", want.result, got.result);
            check_field("accumulator_out", want.acc, got.acc);
            check_field("flag_zero", {7'd0, want.flags.z}, {7'd0, got.flags.z});
            check_field("flag_subtract", {7'd0, want.flags.n}, {7'd0, got.flags.n});
            check_field("flag_half", {7'd0, want.flags.h}, {7'd0, got.flags.h});
            check_field("flag_carry", {7'd0, want.flags.c}, {7'd0, got.flags.c});
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [4:0] req_action;
   logic [7:0] req_value;
   logic [7:0] req_first_operand;
   logic [2:0] req_bit_index;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_result;
   logic [7:0] rsp_accumulator_out;
   logic       rsp_flag_zero;
   logic       rsp_flag_subtract;
   logic       rsp_flag_half;
   logic       rsp_flag_carry;

   acc_flag_board board = new();
   int unsigned   items_sent  = 0;
   int unsigned   cycle_count = 0;
   bit            rx_idle_on  = 1'b0;
   bit            long_hold   = 1'b0;

   sm83_alu_with_flags u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_value           (req_value),
      .req_first_operand   (req_first_operand),
      .req_bit_index       (req_bit_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result          (rsp_result),
      .rsp_accumulator_out (rsp_accumulator_out),
      .rsp_flag_zero       (rsp_flag_zero),
      .rsp_flag_subtract   (rsp_flag_subtract),
      .rsp_flag_half       (rsp_flag_half),
      .rsp_flag_carry      (rsp_flag_carry)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_word(req_action, req_value, req_first_operand, req_bit_index);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_word({rsp_result, rsp_accumulator_out, rsp_flag_zero,
                           rsp_flag_subtract, rsp_flag_half, rsp_flag_carry});
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: per-cycle ready with random stall bursts, plus one long hold-off.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [4:0] act, input logic [7:0] v,
                            input logic [7:0] v1, input logic [2:0] bi);
      req_valid         = 1'b1;
      req_action        = act;
      req_value         = v;
      req_first_operand = v1;
      req_bit_index     = bi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (act <= ACT_LOAD)
         items_sent++;
   endtask

   task automatic idle_gap(input int unsigned cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (board.pending_outs.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return {b[7:4], 4'hF};
         3:       return {b[7:4], 4'h0};
         4:       return {4'h9, b[3:0]};
         default: return b;
      endcase
   endfunction

   function automatic logic [7:0] pick_bcd();
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   // BCD arithmetic followed by a decimal adjust, with random starting flags.
   task automatic send_bcd_run();
      logic [4:0] op;
      case ($urandom_range(0, 3))
         0:       op = ACT_ADC;
         1:       op = ACT_SUB;
         2:       op = ACT_SBC;
         default: op = ACT_ADD;
      endcase
      send_word(ACT_LOAD, pick_bcd(), 8'($urandom_range(0, 255)), 3'd0);
      send_word(op, pick_bcd(), pick_bcd(), 3'($urandom_range(0, 7)));
      send_word(ACT_DAA, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)));
   endtask

   task automatic run_random(input int unsigned count, input bit with_idle);
      int unsigned target;
      int unsigned chunk;
      bit          tx_idle_now;
      target      = items_sent + count;
      chunk       = 0;
      tx_idle_now = with_idle;
      while (items_sent < target) begin
         if (chunk == 0) begin
            // re-roll both sides so quiet stretches occur between busy ones
            chunk       = 64;
            tx_idle_now = with_idle && ($urandom_range(0, 2) != 0);
            rx_idle_on  = with_idle && ($urandom_range(0, 2) != 0);
         end
         chunk--;
         if (tx_idle_now && $urandom_range(0, 5) == 0)
            idle_gap($urandom_range(1, 7));
         if ($urandom_range(0, 11) == 0)
            send_bcd_run();
         else if ($urandom_range(0, 49) == 0)
            send_word(5'($urandom_range(24, 31)), pick_byte(), pick_byte(),
                      3'($urandom_range(0, 7)));
         else
            send_word(5'($urandom_range(0, 23)), pick_byte(), pick_byte(),
                      3'($urandom_range(0, 7)));
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_ADD;
      req_value         = '0;
      req_first_operand = '0;
      req_bit_index     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every action, carry-in and decimal adjust cases
      send_word(ACT_ADD,  8'h01, 8'hFF, 3'd0);
      send_word(ACT_ADC,  8'h0F, 8'h00, 3'd0);
      send_word(ACT_LOAD, 8'h8F, 8'hF0, 3'd0);
      send_word(ACT_SBC,  8'hFF, 8'h00, 3'd0);
      send_word(ACT_LOAD, 8'h00, 8'h10, 3'd0);
      send_word(ACT_SBC,  8'h00, 8'h00, 3'd0);
      send_word(ACT_SUB,  8'h00, 8'h00, 3'd0);
      send_word(ACT_AND,  8'h00, 8'hFF, 3'd0);
      send_word(ACT_OR,   8'hFF, 8'h00, 3'd0);
      send_word(ACT_XOR,  8'hFF, 8'h00, 3'd0);
      send_word(ACT_CP,   8'h01, 8'h00, 3'd0);
      send_word(ACT_BIT,  8'h80, 8'h00, 3'd7);
      send_word(ACT_BIT,  8'hFE, 8'h00, 3'd0);
      send_word(ACT_RL,   8'h80, 8'h00, 3'd0);
      send_word(ACT_RLC,  8'h80, 8'h00, 3'd0);
      send_word(ACT_RR,   8'h01, 8'h00, 3'd0);
      send_word(ACT_RRC,  8'h01, 8'h00, 3'd0);
      send_word(ACT_SLA,  8'hFF, 8'h00, 3'd0);
      send_word(ACT_SRA,  8'h81, 8'h00, 3'd0);
      send_word(ACT_SRL,  8'h01, 8'h00, 3'd0);
      send_word(ACT_SWAP, 8'hF0, 8'h00, 3'd0);
      send_word(ACT_SCF,  8'h00, 8'h00, 3'd0);
      send_word(ACT_CCF,  8'h00, 8'h00, 3'd0);
      send_word(ACT_CPL,  8'h00, 8'h00, 3'd0);
      send_word(ACT_INC,  8'hFF, 8'h00, 3'd0);
      send_word(ACT_DEC,  8'h00, 8'h00, 3'd0);
      send_word(ACT_LOAD, 8'h9A, 8'h00, 3'd0);
      send_word(ACT_DAA,  8'h00, 8'h00, 3'd0);
      send_word(ACT_LOAD, 8'h00, 8'h70, 3'd0);
      send_word(ACT_DAA,  8'h00, 8'h00, 3'd0);
      send_word(ACT_UNUSED, 8'hFF, 8'hFF, 3'd7);

      run_random(600, 1'b1);

      // receiver holds off while words keep coming, so the input side backs up
      wait_drained();
      rx_idle_on = 1'b0;
      long_hold  = 1'b1;
      run_random(50, 1'b0);
      wait_drained();
      idle_gap(3);

      run_random(600, 1'b1);
      rx_idle_on = 1'b0;
      run_random(300, 1'b0);

      wait_drained();
      repeat (8) @(negedge clock);
      if (board.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
